>>> rtl/core/betweenness_centrality_engine_macros.svh
// Assertion macros shared by the betweenness centrality engine checkers.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BETWEENNESS_CENTRALITY_ENGINE_MACROS_SVH
`define BETWEENNESS_CENTRALITY_ENGINE_MACROS_SVH

// same-cycle implication
`define BCE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BCE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/bce_pkg.sv
// Shared types and constants of the betweenness centrality engine.
// No dependencies; imported by bce_if, bce_ratio, bce_ctl, bce_dp, the top level and the checker.
`timescale 1ns / 1ps

package bce_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int VERT_W       = 10;
   localparam int VCNT_W       = 11;
   localparam int KIND_W       = 2;
   localparam int SCORE_W      = 48;
   localparam int STATUS_W     = 2;
   localparam int FRAC_BITS    = 16;
   localparam int DEP_W        = 32;
   localparam int DIST_W       = 11;

   localparam logic [DIST_W-1:0]  DIST_UNV  = '1;
   localparam logic [DEP_W-1:0]   DEP_MAX   = '1;
   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD   = 2'd0,
      KIND_RUN   = 2'd1,
      KIND_READ  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_REJECT   = 2'd1,
      STAT_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECODE, ST_CLR_CENT, ST_INIT, ST_SEED,
      ST_F_RD, ST_F_CHK, ST_F_DA, ST_F_DB, ST_F_SU, ST_F_SW, ST_F_LVL,
      ST_R_RD, ST_R_CHK, ST_R_DA, ST_R_DB, ST_R_RD1, ST_R_RD2, ST_R_DIV,
      ST_R_MUL, ST_R_ACC, ST_R_LVL,
      ST_C_RD, ST_C_WR, ST_S_NEXT, ST_RUN_END, ST_RESP
   } ctl_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_DECODE, OP_CLR_CENT, OP_INIT, OP_SEED,
      OP_EDGE_RD, OP_EDGE_CHK, OP_DIST_A, OP_FWD_DEC, OP_SIG_U, OP_SIG_W,
      OP_LVL_FWD, OP_REV_DEC, OP_REV_RD1, OP_DIV_START, OP_MUL, OP_ACC,
      OP_LVL_REV, OP_CENT_RD, OP_CENT_WR, OP_SRC_NEXT, OP_RUN_END
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     edge_end;
      logic     edge_skip;
      logic     fwd_hit;
      logic     rev_hit;
      logic     found;
      logic     lvl_zero;
      logic     div_done;
      logic     n_zero;
      logic     clr_last;
      logic     vtx_last;
      logic     src_last;
   } dp_stat_type;

endpackage

>>> rtl/core/bce_if.sv
// Valid/ready channel interfaces for the request and response streams.
// Depends on bce_pkg for field widths.
`timescale 1ns / 1ps

interface bce_req_if;
   import bce_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [VERT_W-1:0]   first_vertex;
   logic [VERT_W-1:0]   second_vertex;
   modport source (output valid, kind, first_vertex, second_vertex, input ready);
   modport sink   (input valid, kind, first_vertex, second_vertex, output ready);
endinterface

interface bce_rsp_if;
   import bce_pkg::*;
   logic                valid;
   logic                ready;
   logic [SCORE_W-1:0]  score;
   logic [STATUS_W-1:0] status;
   modport source (output valid, score, status, input ready);
   modport sink   (input valid, score, status, output ready);
endinterface

>>> rtl/core/bce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/bce_ratio.sv
// Iterative fixed-point ratio floor(num * 2^F / den), one quotient bit a cycle;
// 2^F if num >= den, 0 if den is 0. Depends on bce_pkg for FRAC_BITS.
`timescale 1ns / 1ps

module bce_ratio #(
   parameter int NUM_W = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [NUM_W-1:0]             num,
   input  logic [NUM_W-1:0]             den,
   output logic                         done,
   output logic [bce_pkg::FRAC_BITS:0]  ratio
);
   import bce_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [NUM_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     den_ff, den_in;
   logic [FRAC_BITS:0]   q_ff, q_in;
   logic [NUM_W:0]       rem_sh;

   assign rem_sh = {rem_ff, 1'b0};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start) begin
         den_in = den;
         if (den == '0) begin
            q_in    = '0;
            done_in = 1'b1;
         end else if (num >= den) begin
            q_in    = (FRAC_BITS+1)'(1) << FRAC_BITS;
            done_in = 1'b1;
         end else begin
            rem_in  = num;
            q_in    = '0;
            cnt_in  = CNT_W'(FRAC_BITS);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = NUM_W'(rem_sh - {1'b0, den_ff});
            q_in   = {q_ff[FRAC_BITS-1:0], 1'b1};
         end else begin
            rem_in = rem_sh[NUM_W-1:0];
            q_in   = {q_ff[FRAC_BITS-1:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done  = done_ff;
   assign ratio = q_ff;
endmodule

>>> rtl/core/bce_ctl.sv
// Sequencer of the engine: decodes items and steps the run through its phases.
// Depends on bce_pkg for state, command and status types.
`timescale 1ns / 1ps

module bce_ctl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  logic                 out_free,
   input  bce_pkg::dp_stat_type stat,
   output bce_pkg::dp_cmd_type  cmd,
   output logic                 req_ready,
   output logic                 rsp_load
);
   import bce_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.op   = OP_LATCH;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.op   = OP_DECODE;
            state_in = (stat.kind == KIND_RUN) ? ST_CLR_CENT : ST_RESP;
         end
         ST_CLR_CENT: begin
            cmd.op = OP_CLR_CENT;
            if (stat.clr_last) begin
               state_in = stat.n_zero ? ST_RUN_END : ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.op = OP_INIT;
            if (stat.vtx_last) begin
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            cmd.op   = OP_SEED;
            state_in = ST_F_RD;
         end
         ST_F_RD: begin
            cmd.op   = OP_EDGE_RD;
            state_in = ST_F_CHK;
         end
         ST_F_CHK: begin
            cmd.op = OP_EDGE_CHK;
            if (stat.edge_end) begin
               state_in = ST_F_LVL;
            end else if (stat.edge_skip) begin
               state_in = ST_F_RD;
            end else begin
               state_in = ST_F_DA;
            end
         end
         ST_F_DA: begin
            cmd.op   = OP_DIST_A;
            state_in = ST_F_DB;
         end
         ST_F_DB: begin
            cmd.op   = OP_FWD_DEC;
            state_in = stat.fwd_hit ? ST_F_SU : ST_F_RD;
         end
         ST_F_SU: begin
            cmd.op   = OP_SIG_U;
            state_in = ST_F_SW;
         end
         ST_F_SW: begin
            cmd.op   = OP_SIG_W;
            state_in = ST_F_RD;
         end
         ST_F_LVL: begin
            cmd.op = OP_LVL_FWD;
            if (stat.found) begin
               state_in = ST_F_RD;
            end else if (stat.lvl_zero) begin
               state_in = ST_C_RD;
            end else begin
               state_in = ST_R_RD;
            end
         end
         ST_R_RD: begin
            cmd.op   = OP_EDGE_RD;
            state_in = ST_R_CHK;
         end
         ST_R_CHK: begin
            cmd.op = OP_EDGE_CHK;
            if (stat.edge_end) begin
               state_in = ST_R_LVL;
            end else if (stat.edge_skip) begin
               state_in = ST_R_RD;
            end else begin
               state_in = ST_R_DA;
            end
         end
         ST_R_DA: begin
            cmd.op   = OP_DIST_A;
            state_in = ST_R_DB;
         end
         ST_R_DB: begin
            cmd.op   = OP_REV_DEC;
            state_in = stat.rev_hit ? ST_R_RD1 : ST_R_RD;
         end
         ST_R_RD1: begin
            cmd.op   = OP_REV_RD1;
            state_in = ST_R_RD2;
         end
         ST_R_RD2: begin
            cmd.op   = OP_DIV_START;
            state_in = ST_R_DIV;
         end
         ST_R_DIV: begin
            if (stat.div_done) begin
               state_in = ST_R_MUL;
            end
         end
         ST_R_MUL: begin
            cmd.op   = OP_MUL;
            state_in = ST_R_ACC;
         end
         ST_R_ACC: begin
            cmd.op   = OP_ACC;
            state_in = ST_R_RD;
         end
         ST_R_LVL: begin
            cmd.op   = OP_LVL_REV;
            state_in = stat.lvl_zero ? ST_C_RD : ST_R_RD;
         end
         ST_C_RD: begin
            cmd.op   = OP_CENT_RD;
            state_in = ST_C_WR;
         end
         ST_C_WR: begin
            cmd.op   = OP_CENT_WR;
            state_in = stat.vtx_last ? ST_S_NEXT : ST_C_RD;
         end
         ST_S_NEXT: begin
            cmd.op   = OP_SRC_NEXT;
            state_in = stat.src_last ? ST_RUN_END : ST_INIT;
         end
         ST_RUN_END: begin
            cmd.op   = OP_RUN_END;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

>>> rtl/core/bce_dp.sv
// Datapath of the engine: edge, distance, path count, dependency and score
// memories, the ratio unit and the arithmetic. Depends on bce_pkg, bce_ram, bce_ratio.
`timescale 1ns / 1ps

module bce_dp #(
   parameter int MAX_EDGES       = 4096,
   parameter int PATH_COUNT_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bce_pkg::dp_cmd_type            cmd,
   output bce_pkg::dp_stat_type           stat,
   input  logic [bce_pkg::KIND_W-1:0]     req_kind,
   input  logic [bce_pkg::VERT_W-1:0]     req_first,
   input  logic [bce_pkg::VERT_W-1:0]     req_second,
   input  logic                           csr_we,
   input  logic [bce_pkg::VCNT_W-1:0]     csr_data,
   output logic [bce_pkg::SCORE_W-1:0]    rsp_score,
   output logic [bce_pkg::STATUS_W-1:0]   rsp_status
);
   import bce_pkg::*;

   localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EC_W   = $clog2(MAX_EDGES + 1);
   localparam int PCB    = PATH_COUNT_BITS;
   localparam int FAC_W  = DEP_W + 1;
   localparam int PROD_W = FRAC_BITS + 1 + FAC_W;
   localparam int TERM_W = PROD_W - FRAC_BITS;
   localparam int DSUM_W = TERM_W + 1;
   localparam logic [PCB-1:0]    PATH_MAX = '1;
   localparam logic [VCNT_W-1:0] MAXV     = VCNT_W'(MAX_VERTICES);

   // control registers
   logic [VCNT_W-1:0] vc_ff;
   logic [EC_W-1:0]   edges_ff;
   logic              ever_run_ff;
   logic              ovf_ff;
   status_type        status_ff;

   // item and walk registers
   kind_type          kind_ff;
   logic [VERT_W-1:0] a_ff, b_ff;
   logic [VERT_W-1:0] src_ff, vidx_ff;
   logic [EC_W-1:0]   eidx_ff;
   logic [DIST_W-1:0] lvl_ff, da_ff;
   logic              found_ff;
   logic [VERT_W-1:0] ea_ff, eb_ff, u_ff, w_ff;
   logic [PCB-1:0]    su_ff;
   logic [DEP_W-1:0]  dx_ff;
   logic [PROD_W-1:0] prod_ff;

   // memory ports
   logic              e_we, e_re;
   logic [VERT_W-1:0] ea_rd, eb_rd;
   logic              d_we, d_re;
   logic [VERT_W-1:0] d_waddr, d_raddr;
   logic [DIST_W-1:0] d_wdata, d_rd;
   logic              s_we, s_re;
   logic [VERT_W-1:0] s_waddr, s_raddr;
   logic [PCB-1:0]    s_wdata, s_rd;
   logic              x_we, x_re;
   logic [VERT_W-1:0] x_waddr, x_raddr;
   logic [DEP_W-1:0]  x_wdata, x_rd;
   logic              c_we, c_re;
   logic [VERT_W-1:0] c_waddr, c_raddr;
   logic [SCORE_W-1:0] c_wdata, c_rd;

   logic               div_start, div_done;
   logic [FRAC_BITS:0] ratio;

   logic [VCNT_W-1:0] n, n_m1;
   logic [DIST_W-1:0] lvl_p1;
   logic              add_ok, f_a, f_b, r_a, r_b;
   logic [PCB:0]      ssum;
   logic [PCB-1:0]    ssat;
   logic              sovf;
   logic [FAC_W-1:0]  fac;
   logic [DSUM_W-1:0] dsum;
   logic [DEP_W-1:0]  dsat;
   logic [SCORE_W:0]  csum;
   logic [SCORE_W-1:0] csat;

   assign n      = (vc_ff > MAXV) ? MAXV : vc_ff;
   assign n_m1   = n - 1'b1;
   assign lvl_p1 = lvl_ff + 1'b1;
   assign add_ok = (edges_ff < EC_W'(MAX_EDGES)) && ({1'b0, a_ff} < n) && ({1'b0, b_ff} < n);

   assign f_a = (da_ff == lvl_ff) && ((d_rd == DIST_UNV) || (d_rd == lvl_p1));
   assign f_b = (d_rd == lvl_ff) && ((da_ff == DIST_UNV) || (da_ff == lvl_p1));
   assign r_a = (da_ff == lvl_ff) && (d_rd == lvl_p1);
   assign r_b = (d_rd == lvl_ff) && (da_ff == lvl_p1);

   assign ssum = {1'b0, s_rd} + {1'b0, su_ff};
   assign sovf = ssum[PCB];
   assign ssat = sovf ? PATH_MAX : ssum[PCB-1:0];

   assign fac  = {1'b0, dx_ff} + (FAC_W'(1) << FRAC_BITS);
   assign dsum = DSUM_W'(x_rd) + DSUM_W'(prod_ff[PROD_W-1:FRAC_BITS]);
   assign dsat = (dsum > DSUM_W'(DEP_MAX)) ? DEP_MAX : dsum[DEP_W-1:0];
   assign csum = {1'b0, c_rd} + (SCORE_W+1)'(x_rd);
   assign csat = csum[SCORE_W] ? SCORE_MAX : csum[SCORE_W-1:0];

   // status to the sequencer
   always_comb begin
      stat.kind      = kind_ff;
      stat.edge_end  = (eidx_ff >= edges_ff);
      stat.edge_skip = ({1'b0, ea_rd} >= n) || ({1'b0, eb_rd} >= n);
      stat.fwd_hit   = f_a || f_b;
      stat.rev_hit   = r_a || r_b;
      stat.found     = found_ff;
      stat.lvl_zero  = (lvl_ff == '0);
      stat.div_done  = div_done;
      stat.n_zero    = (n == '0);
      stat.clr_last  = ({1'b0, vidx_ff} == MAXV - 1'b1);
      stat.vtx_last  = ({1'b0, vidx_ff} == n_m1);
      stat.src_last  = ({1'b0, src_ff} == n_m1);
   end

   // memory port steering
   always_comb begin
      e_we = 1'b0; e_re = 1'b0;
      d_we = 1'b0; d_re = 1'b0; d_waddr = vidx_ff; d_raddr = ea_rd; d_wdata = DIST_UNV;
      s_we = 1'b0; s_re = 1'b0; s_waddr = vidx_ff; s_raddr = u_ff; s_wdata = '0;
      x_we = 1'b0; x_re = 1'b0; x_waddr = vidx_ff; x_raddr = vidx_ff; x_wdata = '0;
      c_we = 1'b0; c_re = 1'b0; c_waddr = vidx_ff; c_raddr = vidx_ff; c_wdata = '0;
      div_start = 1'b0;
      case (cmd.op)
         OP_DECODE: begin
            e_we    = (kind_ff == KIND_ADD) && add_ok;
            c_re    = (kind_ff == KIND_READ);
            c_raddr = a_ff;
            c_we    = (kind_ff == KIND_RUN);
         end
         OP_CLR_CENT: begin
            c_we = 1'b1;
         end
         OP_INIT: begin
            d_we = 1'b1;
            s_we = 1'b1;
            x_we = 1'b1;
         end
         OP_SEED: begin
            d_we    = 1'b1;
            d_waddr = src_ff;
            d_wdata = '0;
            s_we    = 1'b1;
            s_waddr = src_ff;
            s_wdata = PCB'(1);
         end
         OP_EDGE_RD: begin
            e_re = 1'b1;
         end
         OP_EDGE_CHK: begin
            d_re    = 1'b1;
            d_raddr = ea_rd;
         end
         OP_DIST_A: begin
            d_re    = 1'b1;
            d_raddr = eb_ff;
         end
         OP_FWD_DEC: begin
            s_re    = f_a || f_b;
            s_raddr = f_a ? ea_ff : eb_ff;
         end
         OP_SIG_U: begin
            s_re    = 1'b1;
            s_raddr = w_ff;
         end
         OP_SIG_W: begin
            s_we    = 1'b1;
            s_waddr = w_ff;
            s_wdata = ssat;
            d_we    = 1'b1;
            d_waddr = w_ff;
            d_wdata = lvl_p1;
         end
         OP_REV_DEC: begin
            s_re    = r_a || r_b;
            s_raddr = r_a ? ea_ff : eb_ff;
            x_re    = r_a || r_b;
            x_raddr = r_a ? eb_ff : ea_ff;
         end
         OP_REV_RD1: begin
            s_re    = 1'b1;
            s_raddr = w_ff;
         end
         OP_DIV_START: begin
            div_start = 1'b1;
         end
         OP_MUL: begin
            x_re    = 1'b1;
            x_raddr = u_ff;
         end
         OP_ACC: begin
            x_we    = 1'b1;
            x_waddr = u_ff;
            x_wdata = dsat;
         end
         OP_CENT_RD: begin
            x_re = 1'b1;
            c_re = 1'b1;
         end
         OP_CENT_WR: begin
            c_we    = (vidx_ff != src_ff);
            c_wdata = csat;
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff       <= VCNT_W'(1);
         edges_ff    <= '0;
         ever_run_ff <= 1'b0;
         ovf_ff      <= 1'b0;
         status_ff   <= STAT_OK;
      end else begin
         if (csr_we) begin
            vc_ff <= csr_data;
         end
         case (cmd.op)
            OP_DECODE: begin
               case (kind_ff)
                  KIND_ADD: begin
                     status_ff <= add_ok ? STAT_OK : STAT_REJECT;
                     if (add_ok) begin
                        edges_ff <= edges_ff + 1'b1;
                     end
                  end
                  KIND_RUN: begin
                     ovf_ff      <= 1'b0;
                     ever_run_ff <= 1'b1;
                     status_ff   <= STAT_OK;
                  end
                  KIND_READ: begin
                     status_ff <= ({1'b0, a_ff} < n) ? STAT_OK : STAT_REJECT;
                  end
                  default: begin
                     edges_ff  <= '0;
                     status_ff <= STAT_OK;
                  end
               endcase
            end
            OP_SIG_W: begin
               if (sovf) begin
                  ovf_ff <= 1'b1;
               end
            end
            OP_RUN_END: begin
               status_ff <= ovf_ff ? STAT_OVERFLOW : STAT_OK;
            end
            default: begin
            end
         endcase
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LATCH: begin
            kind_ff <= kind_type'(req_kind);
            a_ff    <= req_first;
            b_ff    <= req_second;
            vidx_ff <= '0;
         end
         OP_CLR_CENT: begin
            vidx_ff <= vidx_ff + 1'b1;
            if (stat.clr_last) begin
               vidx_ff <= '0;
               src_ff  <= '0;
            end
         end
         OP_INIT: begin
            vidx_ff <= stat.vtx_last ? '0 : vidx_ff + 1'b1;
         end
         OP_SEED: begin
            lvl_ff   <= '0;
            found_ff <= 1'b0;
            eidx_ff  <= '0;
         end
         OP_EDGE_CHK: begin
            ea_ff <= ea_rd;
            eb_ff <= eb_rd;
            if (!stat.edge_end && stat.edge_skip) begin
               eidx_ff <= eidx_ff + 1'b1;
            end
         end
         OP_DIST_A: begin
            da_ff <= d_rd;
         end
         OP_FWD_DEC: begin
            u_ff <= f_a ? ea_ff : eb_ff;
            w_ff <= f_a ? eb_ff : ea_ff;
            if (!(f_a || f_b)) begin
               eidx_ff <= eidx_ff + 1'b1;
            end
         end
         OP_SIG_U: begin
            su_ff <= s_rd;
         end
         OP_SIG_W: begin
            found_ff <= 1'b1;
            eidx_ff  <= eidx_ff + 1'b1;
         end
         OP_LVL_FWD: begin
            vidx_ff <= '0;
            eidx_ff <= '0;
            if (found_ff) begin
               lvl_ff   <= lvl_p1;
               found_ff <= 1'b0;
            end else if (lvl_ff != '0) begin
               lvl_ff <= lvl_ff - 1'b1;
            end
         end
         OP_REV_DEC: begin
            u_ff <= r_a ? ea_ff : eb_ff;
            w_ff <= r_a ? eb_ff : ea_ff;
            if (!(r_a || r_b)) begin
               eidx_ff <= eidx_ff + 1'b1;
            end
         end
         OP_REV_RD1: begin
            su_ff <= s_rd;
            dx_ff <= x_rd;
         end
         OP_MUL: begin
            prod_ff <= PROD_W'(ratio) * PROD_W'(fac);
         end
         OP_ACC: begin
            eidx_ff <= eidx_ff + 1'b1;
         end
         OP_LVL_REV: begin
            vidx_ff <= '0;
            eidx_ff <= '0;
            if (lvl_ff != '0) begin
               lvl_ff <= lvl_ff - 1'b1;
            end
         end
         OP_CENT_WR: begin
            vidx_ff <= stat.vtx_last ? '0 : vidx_ff + 1'b1;
         end
         OP_SRC_NEXT: begin
            src_ff  <= src_ff + 1'b1;
            vidx_ff <= '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_status = status_ff;
   assign rsp_score  = ((kind_ff == KIND_READ) && (status_ff == STAT_OK) && ever_run_ff)
                       ? c_rd : '0;

   bce_ram #(.WIDTH(VERT_W), .DEPTH(MAX_EDGES)) u_edge_a (
      .clock(clock), .wr_en(e_we), .wr_addr(edges_ff[EA_W-1:0]), .wr_data(a_ff),
      .rd_en(e_re), .rd_addr(eidx_ff[EA_W-1:0]), .rd_data(ea_rd));

   bce_ram #(.WIDTH(VERT_W), .DEPTH(MAX_EDGES)) u_edge_b (
      .clock(clock), .wr_en(e_we), .wr_addr(edges_ff[EA_W-1:0]), .wr_data(b_ff),
      .rd_en(e_re), .rd_addr(eidx_ff[EA_W-1:0]), .rd_data(eb_rd));

   bce_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist (
      .clock(clock), .wr_en(d_we), .wr_addr(d_waddr), .wr_data(d_wdata),
      .rd_en(d_re), .rd_addr(d_raddr), .rd_data(d_rd));

   bce_ram #(.WIDTH(PCB), .DEPTH(MAX_VERTICES)) u_sigma (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
      .rd_en(s_re), .rd_addr(s_raddr), .rd_data(s_rd));

   bce_ram #(.WIDTH(DEP_W), .DEPTH(MAX_VERTICES)) u_delta (
      .clock(clock), .wr_en(x_we), .wr_addr(x_waddr), .wr_data(x_wdata),
      .rd_en(x_re), .rd_addr(x_raddr), .rd_data(x_rd));

   bce_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_VERTICES)) u_cent (
      .clock(clock), .wr_en(c_we), .wr_addr(c_waddr), .wr_data(c_wdata),
      .rd_en(c_re), .rd_addr(c_raddr), .rd_data(c_rd));

   bce_ratio #(.NUM_W(PCB)) u_ratio (
      .clock(clock), .reset(reset), .start(div_start), .num(su_ff), .den(s_rd),
      .done(div_done), .ratio(ratio));
endmodule

>>> rtl/core/betweenness_centrality_engine.sv
// Betweenness centrality engine (Brandes, unweighted, undirected graph).
// One item at a time: add an edge, clear the edge list, read one vertex score,
// or run the whole computation. Add, clear and read each pass through decode,
// then result load once the output register is free, before the next ready. A
// run clears all 1024 scores, then per source vertex: per-vertex init of n
// entries, a forward breadth-first pass of (levels+1) scans over the edge list
// (each edge is read and checked; one in range also reads both distances, and
// one that extends a path updates the path count), a reverse pass of one scan
// per level (a tree edge waits on the 16-step bit-serial ratio divider), and a
// read and a write per vertex folding dependencies into the scores. Every
// memory has one write and one registered read port, which is what sets the
// per-edge steps. Scores read as zero until the first run.
// Depends on bce_pkg, bce_if, bce_ctl, bce_dp.
`timescale 1ns / 1ps

module betweenness_centrality_engine #(
   parameter int MAX_EDGES       = 4096,
   parameter int PATH_COUNT_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   bce_req_if.sink                     req_ch,
   bce_rsp_if.source                   rsp_ch,
   input  logic                        csr_write_enable,
   input  logic [bce_pkg::VCNT_W-1:0]  csr_write_data
);
   import bce_pkg::*;

   dp_cmd_type           cmd;
   dp_stat_type          stat;
   logic                 req_ready;
   logic                 req_fire;
   logic                 rsp_load;
   logic                 out_free;
   logic [SCORE_W-1:0]   dp_score;
   logic [STATUS_W-1:0]  dp_status;

   // output register: holds a finished result until the sink takes it
   logic                 rsp_valid_ff;
   logic [SCORE_W-1:0]   rsp_score_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;

   assign req_fire = req_ch.valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   bce_ctl u_ctl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .out_free(out_free),
      .stat(stat), .cmd(cmd), .req_ready(req_ready), .rsp_load(rsp_load));

   bce_dp #(.MAX_EDGES(MAX_EDGES), .PATH_COUNT_BITS(PATH_COUNT_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_kind(req_ch.kind), .req_first(req_ch.first_vertex),
      .req_second(req_ch.second_vertex),
      .csr_we(csr_write_enable), .csr_data(csr_write_data),
      .rsp_score(dp_score), .rsp_status(dp_status));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_score_ff  <= dp_score;
         rsp_status_ff <= dp_status;
      end
   end

   assign req_ch.ready  = req_ready;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.score  = rsp_score_ff;
   assign rsp_ch.status = rsp_status_ff;
endmodule

>>> rtl/core/bce_checker.sv
// Port-level checker for the engine, bound to the top level.
// Depends on bce_pkg and betweenness_centrality_engine_macros.svh.
`timescale 1ns / 1ps
`include "betweenness_centrality_engine_macros.svh"

module bce_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bce_pkg::SCORE_W-1:0]   rsp_score,
   input logic [bce_pkg::STATUS_W-1:0]  rsp_status
);
   import bce_pkg::*;

   `BCE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped before transfer")
   `BCE_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "second item taken while one is in work")
   `BCE_ASSERT_NOW(a_reject_zero, clock, reset, rsp_valid && (rsp_status == STAT_REJECT), rsp_score == '0, "rejected item carries a score")
   `BCE_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid, "result valid right after reset")
endmodule

bind betweenness_centrality_engine bce_checker u_bce_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_ch.valid), .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .rsp_score(rsp_ch.score), .rsp_status(rsp_ch.status));
